>>> rtl/pli_pkg.sv
package pli_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int REG_W          = 64;
	localparam int LANE_IDX_W     = 3;
	localparam int CFG_IDX_W      = 2;
	localparam int DEFAULT_POINTS = 8;
	localparam int CNT_W          = $clog2(SAMPLE_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_LOW,
		CFG_X_HIGH,
		CFG_Y_LOW,
		CFG_Y_HIGH
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DIVIDE,
		S_FINISH
	} state_t;

	// operands of the scaled segment offset: off * rise / run
	typedef struct packed {
		logic [SAMPLE_W-1:0] off;
		logic [SAMPLE_W-1:0] run;
		logic [SAMPLE_W-1:0] rise;
	} md_req_t;

	// pick one 16-bit lane out of the low/high register pair
	function automatic logic [SAMPLE_W-1:0] lane16(input logic [REG_W-1:0] lo,
			input logic [REG_W-1:0] hi, input logic [LANE_IDX_W-1:0] idx);
		logic [REG_W-1:0] word;
		word = idx[2] ? hi : lo;
		return word[32'(idx[1:0]) * SAMPLE_W +: SAMPLE_W];
	endfunction

endpackage

>>> rtl/pli_muldiv.sv
module pli_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pli_pkg::md_req_t              req,
	output logic                          done,
	output logic [pli_pkg::SAMPLE_W-1:0]  quotient
);

	localparam int W = pli_pkg::SAMPLE_W;

	logic               busy_q;
	logic               done_q;
	logic [pli_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]       rise_q;
	logic [W-1:0]       off_q;
	logic [W-1:0]       run_q;
	logic [W-1:0]       rem_q;
	logic [W-1:0]       quo_q;

	logic [W+1:0]       trial;
	logic [W+1:0]       run1;
	logic [W+1:0]       run2;
	logic               ge1;
	logic               ge2;
	logic [1:0]         digit;
	logic [W-1:0]       rem_nx;
	logic [W-1:0]       quo_nx;

	// One bit of rise per cycle, MSB first: rem < run holds throughout, so
	// 2*rem + off stays below 3*run and each step yields a digit of 0, 1 or 2.
	always_comb begin
		trial  = {1'b0, rem_q, 1'b0} + {2'b00, (rise_q[W-1] ? off_q : {W{1'b0}})};
		run1   = {2'b00, run_q};
		run2   = {1'b0, run_q, 1'b0};
		ge2    = (trial >= run2);
		ge1    = (trial >= run1);
		if (ge2) begin
			rem_nx = W'(trial - run2);
			digit  = 2'd2;
		end else if (ge1) begin
			rem_nx = W'(trial - run1);
			digit  = 2'd1;
		end else begin
			rem_nx = W'(trial);
			digit  = 2'd0;
		end
		quo_nx = W'({quo_q, 1'b0} + {{(W-1){1'b0}}, digit});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= pli_pkg::CNT_W'(cnt_q + 1'b1);
				if (cnt_q == pli_pkg::CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rise_q <= req.rise;
			off_q  <= req.off;
			run_q  <= req.run;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rise_q <= {rise_q[W-2:0], 1'b0};
			rem_q  <= rem_nx;
			quo_q  <= quo_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear lookup: a 16-bit sample is mapped through up to POINTS
// ascending breakpoints held in four 64-bit registers (x low/high, y low/high,
// reset to zero; the user must write them through the cfg channel only while
// the block is idle, which the block itself does not enforce). Samples at or
// below the first breakpoint give the first output, at or above the last give
// the last; otherwise the search state finds the segment containing the
// sample and y0 +/- off*rise/run is formed, truncated toward zero.
// Flow: an accepted item passes the search state, then the bit-serial
// multiply/divide unit, whose done flag the divide state picks up, then the
// finish state, which loads the result once the output register is free or
// being read; a clamped sample skips the unit (search, load). One item is in
// flight at a time, so a new item is accepted only after the last one is
// loaded; it is accepted while the previous result still waits on out_ready.
module piecewise_linear_interpolator_top #(
	parameter int POINTS = pli_pkg::DEFAULT_POINTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pli_pkg::REG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pli_pkg::SAMPLE_W-1:0]   sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pli_pkg::SAMPLE_W-1:0]   mapped_value
);

	localparam int W     = pli_pkg::SAMPLE_W;
	localparam int SEG_W = $clog2(POINTS);
	localparam int LW    = pli_pkg::LANE_IDX_W;

	pli_pkg::state_t   state_q, state_nx;

	logic [pli_pkg::REG_W-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [W-1:0]      sample_q;
	logic [W-1:0]      y0_q;
	logic              clamp_q;
	logic              falling_q;
	logic              out_valid_q;
	logic [W-1:0]      mapped_value_q;

	logic              at_low, at_high, clamp_c;
	logic [SEG_W-1:0]  seg_c;
	logic [SEG_W-1:0]  seg_prev;
	logic [W-1:0]      x0_c, x1_c, y0_c, y1_c, clamp_y;
	logic              falling_c;
	pli_pkg::md_req_t  md_req;
	logic              md_start;
	logic              md_done;
	logic [W-1:0]      quo;
	logic              out_load;
	logic [W-1:0]      result;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q <= '0;
			x_hi_q <= '0;
			y_lo_q <= '0;
			y_hi_q <= '0;
		end else if (cfg_valid) begin
			case (pli_pkg::cfg_reg_t'(cfg_index))
				pli_pkg::CFG_X_LOW:  x_lo_q <= cfg_data;
				pli_pkg::CFG_X_HIGH: x_hi_q <= cfg_data;
				pli_pkg::CFG_Y_LOW:  y_lo_q <= cfg_data;
				pli_pkg::CFG_Y_HIGH: y_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment search: independent compares, lowest hit wins
	always_comb begin
		at_low  = (sample_q <= pli_pkg::lane16(x_lo_q, x_hi_q, '0));
		at_high = (sample_q >= pli_pkg::lane16(x_lo_q, x_hi_q, LW'(POINTS - 1)));
		clamp_c = at_low || at_high;
		clamp_y = at_low ? pli_pkg::lane16(y_lo_q, y_hi_q, '0)
				: pli_pkg::lane16(y_lo_q, y_hi_q, LW'(POINTS - 1));
		seg_c = SEG_W'(POINTS - 1);
		for (int i = POINTS - 1; i >= 1; i--) begin
			if (sample_q < pli_pkg::lane16(x_lo_q, x_hi_q, LW'(i)))
				seg_c = SEG_W'(i);
		end
		seg_prev  = SEG_W'(seg_c - 1'b1);
		x1_c      = pli_pkg::lane16(x_lo_q, x_hi_q, LW'(seg_c));
		x0_c      = pli_pkg::lane16(x_lo_q, x_hi_q, LW'(seg_prev));
		y1_c      = pli_pkg::lane16(y_lo_q, y_hi_q, LW'(seg_c));
		y0_c      = pli_pkg::lane16(y_lo_q, y_hi_q, LW'(seg_prev));
		falling_c = (y1_c < y0_c);
		md_req.off  = W'(sample_q - x0_c);
		md_req.run  = W'(x1_c - x0_c);
		md_req.rise = falling_c ? W'(y0_c - y1_c) : W'(y1_c - y0_c);
	end

	pli_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (md_start),
		.req      (md_req),
		.done     (md_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pli_pkg::S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		md_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			pli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_nx = pli_pkg::S_SEARCH;
			end
			pli_pkg::S_SEARCH: begin
				if (clamp_c) begin
					state_nx = pli_pkg::S_FINISH;
				end else begin
					md_start = 1'b1;
					state_nx = pli_pkg::S_DIVIDE;
				end
			end
			pli_pkg::S_DIVIDE: begin
				if (md_done)
					state_nx = pli_pkg::S_FINISH;
			end
			pli_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_nx = pli_pkg::S_IDLE;
				end
			end
			default: state_nx = pli_pkg::S_IDLE;
		endcase
	end

	// item payload and segment terms
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_q <= sample;
		if (state_q == pli_pkg::S_SEARCH) begin
			clamp_q   <= clamp_c;
			falling_q <= falling_c;
			y0_q      <= clamp_c ? clamp_y : y0_c;
		end
	end

	always_comb begin
		if (clamp_q)
			result = y0_q;
		else if (falling_q)
			result = W'(y0_q - quo);
		else
			result = W'(y0_q + quo);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			mapped_value_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign mapped_value = mapped_value_q;

endmodule
